FILE: rtl/rcs_pkg.sv
package rcs_pkg;

    localparam int NUM_CH  = 3;
    localparam int PIX_W   = 8;
    localparam int NUM_W   = 2 * PIX_W;
    localparam int CNT_W   = 3;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    localparam logic [PIX_W-1:0] TRK_MIN_RST = 8'd255;
    localparam logic [PIX_W-1:0] TRK_MAX_RST = 8'd0;
    localparam logic [CNT_W-1:0] STEP_LAST   = CNT_W'(PIX_W - 1);

    typedef logic [PIX_W-1:0] pix_t;

    typedef enum logic {
        OP_MEASURE = 1'b0,
        OP_STRETCH = 1'b1
    } op_t;

    // one stretch job: clamped offset from min and the channel span
    typedef struct packed {
        pix_t [NUM_CH-1:0] offset;
        pix_t [NUM_CH-1:0] span;
    } work_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_HOLD
    } back_state_t;

endpackage

FILE: rtl/rgb_contrast_stretch_core.sv
// Per-channel min/max contrast stretch for 8-bit RGB. Send the frame twice:
// first as measure beats (s_tuser[0] = 0; s_tuser[1] set on the first beat
// restarts the min/max trackers), then as stretch beats (s_tuser[0] = 1),
// each of which returns one beat with floor((v-min)*255/(max-min)) per
// channel, 0 for a flat or empty channel and saturated outside min..max.
// Measure beats produce nothing, but like stretch beats they wait while
// the queue is full. A stretch beat is clamped against the trackers on
// entry and queued (two deep); the back end runs three restoring dividers
// side by side, one quotient bit per cycle, so each stretched pixel
// occupies it for one load plus eight bit steps, which sets the sustained
// stretch rate. Results sit in an output register, so a stalled m_tready
// holds one result while up to three more stretch beats are still
// accepted (one parked in the divider, two queued).
module rgb_contrast_stretch_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
    input  logic [1:0]  s_tuser,   // operation, frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red_out, green_out, blue_out
);

    logic           push_valid, push_ready;
    logic           pop_valid, pop_ready;
    rcs_pkg::work_t push_data, pop_data;

    rcs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    rcs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    rcs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: rtl/rcs_front.sv
module rcs_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // red_in, green_in, blue_in
    input  logic [1:0]            s_tuser,   // operation, frame_start
    output logic                  push_valid,
    input  logic                  push_ready,
    output rcs_pkg::work_t        push_data
);

    rcs_pkg::pix_t min_reg  [rcs_pkg::NUM_CH];
    rcs_pkg::pix_t min_next [rcs_pkg::NUM_CH];
    rcs_pkg::pix_t max_reg  [rcs_pkg::NUM_CH];
    rcs_pkg::pix_t max_next [rcs_pkg::NUM_CH];
    rcs_pkg::pix_t pix      [rcs_pkg::NUM_CH];
    rcs_pkg::pix_t base_mn  [rcs_pkg::NUM_CH];
    rcs_pkg::pix_t base_mx  [rcs_pkg::NUM_CH];
    rcs_pkg::pix_t range    [rcs_pkg::NUM_CH];
    rcs_pkg::op_t  op;
    logic          fs;
    logic          accept;

    assign op       = rcs_pkg::op_t'(s_tuser[0]);
    assign fs       = s_tuser[1];
    assign s_tready = push_ready;
    assign accept   = s_tvalid && push_ready;
    assign push_valid = s_tvalid && (op == rcs_pkg::OP_STRETCH);

    always_comb begin
        for (int ch = 0; ch < rcs_pkg::NUM_CH; ch++) begin
            pix[ch]   = s_tdata[ch*rcs_pkg::PIX_W +: rcs_pkg::PIX_W];
            range[ch] = max_reg[ch] - min_reg[ch];

            // measure: optional restart, then fold in this pixel
            base_mn[ch]  = fs ? rcs_pkg::TRK_MIN_RST : min_reg[ch];
            base_mx[ch]  = fs ? rcs_pkg::TRK_MAX_RST : max_reg[ch];
            min_next[ch] = min_reg[ch];
            max_next[ch] = max_reg[ch];
            if (accept && op == rcs_pkg::OP_MEASURE) begin
                min_next[ch] = (pix[ch] < base_mn[ch]) ? pix[ch] : base_mn[ch];
                max_next[ch] = (pix[ch] > base_mx[ch]) ? pix[ch] : base_mx[ch];
            end

            // stretch: clamp so the divider sees offset <= span, span > 0
            priority if (max_reg[ch] <= min_reg[ch] || pix[ch] <= min_reg[ch]) begin
                push_data.offset[ch] = '0;
                push_data.span[ch]   = rcs_pkg::PIX_W'(1);
            end else if (pix[ch] >= max_reg[ch]) begin
                push_data.offset[ch] = range[ch];
                push_data.span[ch]   = range[ch];
            end else begin
                push_data.offset[ch] = pix[ch] - min_reg[ch];
                push_data.span[ch]   = range[ch];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int ch = 0; ch < rcs_pkg::NUM_CH; ch++) begin
            if (!aresetn) begin
                min_reg[ch] <= rcs_pkg::TRK_MIN_RST;
                max_reg[ch] <= rcs_pkg::TRK_MAX_RST;
            end else begin
                min_reg[ch] <= min_next[ch];
                max_reg[ch] <= max_next[ch];
            end
        end
    end

endmodule

FILE: rtl/rcs_queue.sv
module rcs_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  rcs_pkg::work_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output rcs_pkg::work_t pop_data
);

    rcs_pkg::work_t                    slot_reg [rcs_pkg::QDEPTH];
    logic [rcs_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [rcs_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [rcs_pkg::QCNT_W-1:0]        cnt_reg, cnt_next;
    logic                              do_push, do_pop;

    assign push_ready = (cnt_reg != rcs_pkg::QCNT_W'(rcs_pkg::QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/rcs_back.sv
module rcs_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  rcs_pkg::work_t pop_data,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [23:0]    m_tdata    // red_out, green_out, blue_out
);

    rcs_pkg::back_state_t        state_reg, state_next;
    logic [rcs_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    rcs_pkg::pix_t               rem_reg  [rcs_pkg::NUM_CH];
    rcs_pkg::pix_t               rem_next [rcs_pkg::NUM_CH];
    rcs_pkg::pix_t               shf_reg  [rcs_pkg::NUM_CH];
    rcs_pkg::pix_t               shf_next [rcs_pkg::NUM_CH];
    rcs_pkg::pix_t               span_reg [rcs_pkg::NUM_CH];
    rcs_pkg::pix_t               span_next[rcs_pkg::NUM_CH];
    rcs_pkg::pix_t               rem_step [rcs_pkg::NUM_CH];
    rcs_pkg::pix_t               shf_step [rcs_pkg::NUM_CH];
    logic [rcs_pkg::PIX_W:0]     trial    [rcs_pkg::NUM_CH];
    logic [rcs_pkg::PIX_W:0]     diff     [rcs_pkg::NUM_CH];
    logic [rcs_pkg::NUM_W-1:0]   num      [rcs_pkg::NUM_CH];
    logic                        ge       [rcs_pkg::NUM_CH];
    logic                        m_valid_reg, m_valid_next;
    logic [23:0]                 m_data_reg, m_data_next;
    logic                        out_free;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign out_free = !m_valid_reg || m_tready;

    // one restoring step per lane; numerator = offset*255, quotient shifts into shf
    always_comb begin
        for (int ch = 0; ch < rcs_pkg::NUM_CH; ch++) begin
            trial[ch]    = {rem_reg[ch], shf_reg[ch][rcs_pkg::PIX_W-1]};
            diff[ch]     = trial[ch] - {1'b0, span_reg[ch]};
            ge[ch]       = (trial[ch] >= {1'b0, span_reg[ch]});
            rem_step[ch] = ge[ch] ? diff[ch][rcs_pkg::PIX_W-1:0]
                                  : trial[ch][rcs_pkg::PIX_W-1:0];
            shf_step[ch] = {shf_reg[ch][rcs_pkg::PIX_W-2:0], ge[ch]};
            num[ch]      = {pop_data.offset[ch], rcs_pkg::PIX_W'(0)}
                         - {rcs_pkg::PIX_W'(0), pop_data.offset[ch]};
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        pop_ready    = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        for (int ch = 0; ch < rcs_pkg::NUM_CH; ch++) begin
            rem_next[ch]  = rem_reg[ch];
            shf_next[ch]  = shf_reg[ch];
            span_next[ch] = span_reg[ch];
        end

        unique case (state_reg)
            rcs_pkg::BK_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    for (int ch = 0; ch < rcs_pkg::NUM_CH; ch++) begin
                        rem_next[ch]  = num[ch][rcs_pkg::NUM_W-1:rcs_pkg::PIX_W];
                        shf_next[ch]  = num[ch][rcs_pkg::PIX_W-1:0];
                        span_next[ch] = pop_data.span[ch];
                    end
                    cnt_next   = '0;
                    state_next = rcs_pkg::BK_DIV;
                end
            end
            rcs_pkg::BK_DIV: begin
                for (int ch = 0; ch < rcs_pkg::NUM_CH; ch++) begin
                    rem_next[ch] = rem_step[ch];
                    shf_next[ch] = shf_step[ch];
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == rcs_pkg::STEP_LAST) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        for (int ch = 0; ch < rcs_pkg::NUM_CH; ch++) begin
                            m_data_next[ch*rcs_pkg::PIX_W +: rcs_pkg::PIX_W] = shf_step[ch];
                        end
                        state_next = rcs_pkg::BK_IDLE;
                    end else begin
                        state_next = rcs_pkg::BK_HOLD;
                    end
                end
            end
            rcs_pkg::BK_HOLD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    for (int ch = 0; ch < rcs_pkg::NUM_CH; ch++) begin
                        m_data_next[ch*rcs_pkg::PIX_W +: rcs_pkg::PIX_W] = shf_reg[ch];
                    end
                    state_next = rcs_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = rcs_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rcs_pkg::BK_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        for (int ch = 0; ch < rcs_pkg::NUM_CH; ch++) begin
            rem_reg[ch]  <= rem_next[ch];
            shf_reg[ch]  <= shf_next[ch];
            span_reg[ch] <= span_next[ch];
        end
    end

endmodule

FILE: rtl/rcs_checker.sv
module rcs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // stretch beats accepted but not yet delivered
    logic [3:0] pending_reg, pending_next;
    logic       s_stretch, m_beat;

    assign s_stretch = s_tvalid && s_tready
                       && (rcs_pkg::op_t'(s_tuser[0]) == rcs_pkg::OP_STRETCH);
    assign m_beat    = m_tvalid && m_tready;

    always_comb begin
        pending_next = pending_reg;
        if (s_stretch && !m_beat) begin
            pending_next = pending_reg + 1'b1;
        end else if (m_beat && !s_stretch) begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != 4'd0)
        else $error("result beat without a pending stretch");

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg == 4'd0 |-> s_tready)
        else $error("input stalled with nothing in flight");

    a_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= 4'd4)
        else $error("more stretch beats in flight than storage");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

endmodule

bind rgb_contrast_stretch_core rcs_checker u_rcs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
